/* design/lirs_pkg.sv */
// ----------------------------------------------------------------------------
// lirs_pkg: shared types and constants
// Request payloads, op codes, controller states and generator constants.
// ----------------------------------------------------------------------------
package lirs_pkg;

  localparam int unsigned ResDepthDefault = 16;
  localparam logic [63:0] GenMult = 64'h2545f4914f6cdd1d;
  localparam logic [63:0] SeedReset = 64'd1;

  typedef enum logic [1:0] {
    OP_RECV  = 2'd0,
    OP_DROP  = 2'd1,
    OP_TICK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] latency;
    logic [31:0] drop_count;
    logic [63:0] now;
  } in_item_t;

  typedef struct packed {
    logic [63:0] elapsed;
    logic [31:0] received_in_bucket;
    logic [63:0] dropped_in_bucket;
    logic [63:0] latency_sum;
    logic [63:0] latency_min;
    logic [63:0] latency_max;
    logic [63:0] sample_value;
    logic        sample_valid;
    logic        last;
    logic [63:0] total_received;
    logic [63:0] total_dropped;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW,
    ST_MULT,
    ST_DIV,
    ST_STORE,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  // divider control between controller and divider
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;

  // one xorshift step
  function automatic logic [63:0] xs_step(input logic [63:0] s);
    logic [63:0] x;
    x = s ^ (s >> 12);
    x = x ^ (x << 25);
    x = x ^ (x >> 27);
    return x;
  endfunction

endpackage

/* design/lirs_div.sv */
// ----------------------------------------------------------------------------
// lirs_div: radix-2 restoring modulo unit
// Computes a 64-bit dividend modulo a 32-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module lirs_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [63:0]           dividend,
  input  logic [31:0]           divisor,
  output lirs_pkg::div_ctl_t    status,
  output logic [31:0]           remainder
);

  logic [63:0] quo;
  logic [32:0] rem;
  logic [31:0] dsr;
  logic [6:0]  count;
  logic        busy;
  logic        done;
  logic [32:0] shifted;
  logic [33:0] diff;

  // shift in next dividend bit and trial subtract
  always_comb begin
    shifted = {rem[31:0], quo[63]};
    diff = {1'b0, shifted} - {2'b00, dsr};
  end

  // iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 7'd64;
      end else if (busy) begin
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      quo <= {quo[62:0], 1'b0};
      rem <= diff[33] ? shifted : diff[32:0];
    end
  end

  assign remainder = rem[31:0];
  assign status = '{start: start, busy: busy, done: done};

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without busy");

  property p_rem_below_divisor;
    @(posedge clk) disable iff (rst) done |-> (rem < {1'b0, dsr});
  endproperty
  a_rem_below_divisor: assert property (p_rem_below_divisor) else $error("remainder too big");

  property p_no_restart;
    @(posedge clk) disable iff (rst) busy |-> !start;
  endproperty
  a_no_restart: assert property (p_no_restart) else $error("start while busy");

endmodule

/* design/lirs_mem.sv */
// ----------------------------------------------------------------------------
// lirs_mem: reservoir storage
// Synchronous memory, one write port and one registered read port.
// ----------------------------------------------------------------------------
module lirs_mem #(
  parameter int unsigned Depth = lirs_pkg::ResDepthDefault,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [63:0]      wdata,
  input  logic [AddrW-1:0] raddr,
  output logic [63:0]      rdata
);

  logic [63:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/latency_interval_reservoir_sampler.sv */
// ----------------------------------------------------------------------------
// latency_interval_reservoir_sampler: interval statistics and latency reservoir
// Interval count/sum/min/max, drop counters and an Algorithm R reservoir.
// ----------------------------------------------------------------------------
// Receive with free reservoir slot, drop, clear, quiet tick: input is not stalled.
// Receive with a full reservoir stalls the input through draw, multiply,
// bit-serial modulo and store; the next request goes in once back in idle.
// Tick with a run: one reservoir memory read per result, in EMIT_RD then EMIT.
// One request is worked on at a time; the result register frees the input side.
// Reset (synchronous) clears all statistics and loads the generator with 1.
// ----------------------------------------------------------------------------
module latency_interval_reservoir_sampler #(
  parameter int unsigned ReservoirSize = lirs_pkg::ResDepthDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [63:0]          cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lirs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lirs_pkg::out_item_t  out_data
);

  localparam int unsigned AddrW = (ReservoirSize > 1) ? $clog2(ReservoirSize) : 1;
  localparam int unsigned FillW = $clog2(ReservoirSize + 1);
  localparam logic [FillW-1:0] FillFull = FillW'(ReservoirSize);

  lirs_pkg::state_t state, state_next;

  logic [FillW-1:0] fill;
  logic [31:0] icount;
  logic [63:0] idrop, isum, imin, imax, rtotal, dtotal, last_tick, gen;
  logic [63:0] lat;
  logic [63:0] prod;
  logic [63:0] tick_now, elapsed;
  logic [FillW-1:0] run_n, k;

  logic [1:0]  mstep;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic in_acc, out_acc;
  logic div_start;
  lirs_pkg::div_ctl_t div_st;
  logic [31:0] div_rem;

  logic mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [63:0] mem_wdata, mem_rdata;

  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign in_stall = (state != lirs_pkg::ST_IDLE);

  // controller next state
  always_comb begin
    state_next = state;
    div_start = 1'b0;
    unique case (state)
      lirs_pkg::ST_IDLE: begin
        if (in_acc && in_data.op == lirs_pkg::OP_RECV && fill == FillFull) begin
          state_next = lirs_pkg::ST_DRAW;
        end else if (in_acc && in_data.op == lirs_pkg::OP_TICK && last_tick != 64'd0
                     && in_data.now != last_tick) begin
          state_next = lirs_pkg::ST_EMIT_RD;
        end
      end
      lirs_pkg::ST_DRAW: state_next = lirs_pkg::ST_MULT;
      lirs_pkg::ST_MULT: begin
        if (mstep == 2'd3) begin
          div_start = 1'b1;
          state_next = lirs_pkg::ST_DIV;
        end
      end
      lirs_pkg::ST_DIV: if (div_st.done) state_next = lirs_pkg::ST_STORE;
      lirs_pkg::ST_STORE: state_next = lirs_pkg::ST_IDLE;
      lirs_pkg::ST_EMIT_RD: if (!out_valid || out_acc) state_next = lirs_pkg::ST_EMIT;
      lirs_pkg::ST_EMIT: begin
        if (k == run_n) state_next = lirs_pkg::ST_IDLE;
        else state_next = lirs_pkg::ST_EMIT_RD;
      end
      default: state_next = lirs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= lirs_pkg::ST_IDLE;
    else state <= state_next;
  end

  // reservoir memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = fill[AddrW-1:0];
    mem_wdata = in_data.latency;
    mem_raddr = k[AddrW-1:0];
    if (state == lirs_pkg::ST_IDLE && in_acc && in_data.op == lirs_pkg::OP_RECV
        && fill != FillFull) begin
      mem_we = 1'b1;
    end else if (state == lirs_pkg::ST_STORE && {32'd0, div_rem} < {{(64-FillW){1'b0}}, fill}) begin
      mem_we = 1'b1;
      mem_waddr = div_rem[AddrW-1:0];
      mem_wdata = lat;
    end
  end

  lirs_mem #(.Depth(ReservoirSize)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  lirs_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(prod),
    .divisor(icount), .status(div_st), .remainder(div_rem)
  );

  // statistics and generator
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0; icount <= '0; idrop <= '0; isum <= '0; imin <= '0; imax <= '0;
      rtotal <= '0; dtotal <= '0; last_tick <= '0; gen <= lirs_pkg::SeedReset;
      k <= '0; run_n <= '0;
    end else begin
      if (cfg_we) gen <= cfg_wdata;
      if (state == lirs_pkg::ST_IDLE && in_acc) begin
        unique case (lirs_pkg::op_t'(in_data.op))
          lirs_pkg::OP_RECV: begin
            lat <= in_data.latency;
            rtotal <= rtotal + 64'd1;
            if (icount == 32'd0) begin
              imin <= in_data.latency;
              imax <= in_data.latency;
            end else begin
              if (in_data.latency < imin) imin <= in_data.latency;
              if (in_data.latency > imax) imax <= in_data.latency;
            end
            if (icount != 32'hFFFF_FFFF) icount <= icount + 32'd1;
            isum <= isum + in_data.latency;
            if (fill != FillFull) fill <= fill + FillW'(1);
          end
          lirs_pkg::OP_DROP: begin
            idrop <= idrop + {32'd0, in_data.drop_count};
            dtotal <= dtotal + {32'd0, in_data.drop_count};
          end
          lirs_pkg::OP_TICK: begin
            if (last_tick == 64'd0) begin
              last_tick <= in_data.now;
            end else if (in_data.now != last_tick) begin
              tick_now <= in_data.now;
              elapsed <= in_data.now - last_tick;
              run_n <= (fill == '0) ? FillW'(1) : fill;
              k <= '0;
            end
          end
          lirs_pkg::OP_CLEAR: begin
            fill <= '0; icount <= '0; idrop <= '0; isum <= '0; imin <= '0; imax <= '0;
            rtotal <= '0; dtotal <= '0; last_tick <= '0;
          end
          default: ;
        endcase
      end
      if (state == lirs_pkg::ST_DRAW) gen <= lirs_pkg::xs_step(gen);
      if (state == lirs_pkg::ST_EMIT) begin
        if (k == run_n) begin
          fill <= '0; icount <= '0; idrop <= '0; isum <= '0; imin <= '0; imax <= '0;
          last_tick <= tick_now;
        end
      end
      if (state == lirs_pkg::ST_EMIT_RD && (!out_valid || out_acc)) k <= k + FillW'(1);
    end
  end

  // multiply step counter
  always_ff @(posedge clk) begin
    if (rst) mstep <= '0;
    else if (state == lirs_pkg::ST_MULT) mstep <= mstep + 2'd1;
    else mstep <= '0;
  end

  // 32x32 partial product select, low 64 bits of the scrambling multiply
  always_comb begin
    unique case (mstep)
      2'd0: begin
        mul_a = gen[31:0];
        mul_b = lirs_pkg::GenMult[31:0];
      end
      2'd1: begin
        mul_a = gen[31:0];
        mul_b = lirs_pkg::GenMult[63:32];
      end
      default: begin
        mul_a = gen[63:32];
        mul_b = lirs_pkg::GenMult[31:0];
      end
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // scrambling multiply accumulated from the three partial products, held for the modulo
  always_ff @(posedge clk) begin
    if (state == lirs_pkg::ST_MULT) begin
      unique case (mstep)
        2'd0: prod <= mul_p;
        2'd1, 2'd2: prod <= prod + {mul_p[31:0], 32'd0};
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == lirs_pkg::ST_EMIT && k != run_n + FillW'(1)) begin
      out_valid <= 1'b1;
    end else if (out_acc) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lirs_pkg::ST_EMIT) begin
      out_data.elapsed <= elapsed;
      out_data.received_in_bucket <= icount;
      out_data.dropped_in_bucket <= idrop;
      out_data.latency_sum <= isum;
      out_data.latency_min <= imin;
      out_data.latency_max <= imax;
      out_data.sample_valid <= (k - FillW'(1)) < fill;
      out_data.sample_value <= ((k - FillW'(1)) < fill) ? mem_rdata : 64'd0;
      out_data.last <= (k == run_n);
      out_data.total_received <= rtotal;
      out_data.total_dropped <= dtotal;
    end
  end

  property p_stall_when_busy;
    @(posedge clk) disable iff (rst) (state != lirs_pkg::ST_IDLE) |-> in_stall;
  endproperty
  a_stall_when_busy: assert property (p_stall_when_busy) else $error("input open while busy");

  property p_emit_slot_free;
    @(posedge clk) disable iff (rst)
      (state == lirs_pkg::ST_EMIT) |-> ($past(!out_valid) || $past(out_acc));
  endproperty
  a_emit_slot_free: assert property (p_emit_slot_free) else $error("result overwritten");

  property p_fill_bound;
    @(posedge clk) disable iff (rst) fill <= FillFull;
  endproperty
  a_fill_bound: assert property (p_fill_bound) else $error("fill overflow");

endmodule
